// ===== rtl/core/touch_to_mouse_event_converter_top_macros.svh =====
// Assertion macros for the touch to mouse event converter.
// Expects clk and rst_n in the scope of each use; empty under SYNTHESIS.
`ifndef TOUCH_TO_MOUSE_EVENT_CONVERTER_TOP_MACROS_SVH
`define TOUCH_TO_MOUSE_EVENT_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TTM_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ttm check failed");

`define TTM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ttm check failed");

`else

`define TTM_ASSERT_SAME(lbl, pre, post)

`define TTM_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/core/ttm_pkg.sv =====
// Shared types, codes and arithmetic helpers of the touch to mouse converter.
// No dependencies.
package ttm_pkg;

  localparam int MAX_OPS        = 5;
  localparam int OP_IDX_W       = $clog2(MAX_OPS);
  localparam int OP_CNT_W       = $clog2(MAX_OPS + 1);
  localparam int TTM_QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_UP     = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_MOVE = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;
  localparam logic [1:0] EV_UP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_DELAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DTAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER    = 3'd7;

  typedef enum logic [2:0] {
    TK_PREMOVE,
    TK_DOWN,
    TK_UP,
    TK_DTDOWN,
    TK_MOVE
  } time_kind_t;

  typedef struct packed {
    logic [1:0]         ev;
    time_kind_t         tk;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } op_t;

  typedef struct packed {
    logic                handled;
    logic [31:0]         now;
    logic [OP_CNT_W-1:0] nops;
    op_t [MAX_OPS-1:0]   ops;
  } cmd_t;

  typedef struct packed {
    logic        delay_en;
    logic [15:0] start;
    logic [15:0] down;
    logic [15:0] up;
    logic        dtap;
    logic [11:0] dead;
    logic [11:0] jit;
    logic [11:0] trig;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic op_t mk_op(logic [1:0] ev, time_kind_t tk,
                                logic signed [15:0] x, logic signed [15:0] y);
    op_t o;
    o.ev = ev;
    o.tk = tk;
    o.x  = x;
    o.y  = y;
    return o;
  endfunction

  function automatic logic abs_le(logic signed [15:0] a, logic signed [15:0] b,
                                  logic [11:0] lim);
    logic signed [17:0] d;
    logic [17:0]        mag;
    d   = {{2{a[15]}}, a} - {{2{b[15]}}, b};
    mag = d[17] ? 18'(-d) : 18'(d);
    return mag <= {6'b0, lim};
  endfunction

  function automatic logic signed [15:0] sat_jit(logic signed [15:0] a, logic [11:0] lim,
                                                 logic neg);
    logic signed [17:0] s;
    if (neg) begin
      s = {{2{a[15]}}, a} - $signed({6'b0, lim});
    end else begin
      s = {{2{a[15]}}, a} + $signed({6'b0, lim});
    end
    if (s > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (s < -18'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  function automatic logic [31:0] tadd(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] tmax(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/ttm_front.sv =====
// Front end: classifies touch requests, keeps pointer and down-point state,
// and builds one command of up to five mouse operations. Uses ttm_pkg.
module ttm_front
  import ttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_pointer_tag,
  input  logic               in_is_mouse,
  input  logic signed [15:0] in_touch_x,
  input  logic signed [15:0] in_touch_y,
  input  logic signed [15:0] in_cursor_x,
  input  logic signed [15:0] in_cursor_y,
  input  logic [31:0]        in_now_ms,
  output logic               push,
  output cmd_t               cmd
);

  logic [31:0] active_r, active_nxt;
  logic        down_r, down_nxt;
  logic        drag_r, drag_nxt;
  logic        pending_r, pending_nxt;
  logic        jpos_r, jpos_nxt;
  logic [31:0] raw_xy_r, raw_xy_nxt;
  logic [31:0] jit_xy_r, jit_xy_nxt;

  logic               ignored, path_down, path_up, path_upd;
  logic signed [15:0] jx, jy, rx, ry, jpx, jpy;
  logic               near_jit, trig_new, trig_old, dead_in;

  assign push = in_valid && !in_stall;

  assign jx = jit_xy_r[15:0];
  assign jy = jit_xy_r[31:16];
  assign rx = raw_xy_r[15:0];
  assign ry = raw_xy_r[31:16];

  assign ignored   = in_is_mouse || (in_kind != KIND_DOWN && active_r != in_pointer_tag);
  assign path_down = !ignored && in_kind == KIND_DOWN && !down_r;
  assign path_up   = !ignored && in_kind == KIND_UP && down_r;
  assign path_upd  = !ignored && in_kind == KIND_UPDATE && down_r;

  assign near_jit = abs_le(in_touch_x, jx, cfg.jit) && abs_le(in_touch_y, jy, cfg.jit);
  assign jpx = near_jit ? sat_jit(in_touch_x, cfg.jit, !jpos_r) : in_touch_x;
  assign jpy = near_jit ? sat_jit(in_touch_y, cfg.jit, !jpos_r) : in_touch_y;
  assign trig_new = !(abs_le(in_cursor_x, jpx, cfg.trig) && abs_le(in_cursor_y, jpy, cfg.trig));
  assign trig_old = !(abs_le(in_cursor_x, jx, cfg.trig) && abs_le(in_cursor_y, jy, cfg.trig));
  assign dead_in  = abs_le(rx, in_touch_x, cfg.dead) && abs_le(ry, in_touch_y, cfg.dead);

  always_comb begin
    logic [OP_CNT_W-1:0] n;
    n           = '0;
    cmd         = '0;
    active_nxt  = active_r;
    down_nxt    = down_r;
    drag_nxt    = drag_r;
    pending_nxt = pending_r;
    jpos_nxt    = jpos_r;
    raw_xy_nxt  = raw_xy_r;
    jit_xy_nxt  = jit_xy_r;
    cmd.handled = path_down || path_up || path_upd;
    cmd.now     = in_now_ms;
    if (path_down) begin
      raw_xy_nxt = {in_touch_y, in_touch_x};
      if (near_jit) begin
        jpos_nxt = !jpos_r;
      end
      jit_xy_nxt = {jpy, jpx};
      if (cfg.delay_en) begin
        pending_nxt = 1'b1;
      end else begin
        if (trig_new) begin
          cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_MOVE, TK_PREMOVE, jpx, jpy);
          n = n + 1'b1;
        end
        cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_DOWN, TK_DOWN, jpx, jpy);
        n = n + 1'b1;
      end
      active_nxt = in_pointer_tag;
      down_nxt   = 1'b1;
    end
    if (path_up) begin
      if (pending_r) begin
        if (trig_old) begin
          cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_MOVE, TK_PREMOVE, jx, jy);
          n = n + 1'b1;
        end
        cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_DOWN, TK_DOWN, jx, jy);
        n = n + 1'b1;
      end
      active_nxt  = '0;
      down_nxt    = 1'b0;
      drag_nxt    = 1'b0;
      pending_nxt = 1'b0;
      if (dead_in) begin
        cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_UP, TK_UP, rx, ry);
      end else begin
        cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_UP, TK_UP, in_touch_x, in_touch_y);
      end
      n = n + 1'b1;
    end
    if (path_upd) begin
      if (drag_r) begin
        cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_MOVE, TK_MOVE, in_touch_x, in_touch_y);
        n = n + 1'b1;
      end else if (!dead_in) begin
        if (pending_r) begin
          if (trig_old) begin
            cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_MOVE, TK_PREMOVE, jx, jy);
            n = n + 1'b1;
          end
          cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_DOWN, TK_DOWN, jx, jy);
          n = n + 1'b1;
          pending_nxt = 1'b0;
        end
        drag_nxt = 1'b1;
        if (cfg.dtap) begin
          cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_UP, TK_UP, jx, jy);
          n = n + 1'b1;
          cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_DOWN, TK_DTDOWN, jx, jy);
          n = n + 1'b1;
        end
        cmd.ops[n[OP_IDX_W-1:0]] = mk_op(EV_MOVE, TK_MOVE, in_touch_x, in_touch_y);
        n = n + 1'b1;
      end
    end
    cmd.nops = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      down_r    <= 1'b0;
      drag_r    <= 1'b0;
      pending_r <= 1'b0;
      jpos_r    <= 1'b1;
      raw_xy_r  <= '0;
      jit_xy_r  <= '0;
    end else if (push) begin
      active_r  <= active_nxt;
      down_r    <= down_nxt;
      drag_r    <= drag_nxt;
      pending_r <= pending_nxt;
      jpos_r    <= jpos_nxt;
      raw_xy_r  <= raw_xy_nxt;
      jit_xy_r  <= jit_xy_nxt;
    end
  end

endmodule

// ===== rtl/core/ttm_queue.sv =====
// Command queue between front and back end of the converter.
// Register-based FIFO of cmd_t entries; uses ttm_pkg.
module ttm_queue
  import ttm_pkg::*;
#(
  parameter int DEPTH = TTM_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign stat.empty = count_r == '0;
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/core/ttm_back.sv =====
// Back end: walks the head command one operation per unstalled cycle, schedules event
// times against the stored event history and drives the result register. Uses ttm_pkg.
module ttm_back
  import ttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               head,
  input  q_stat_t            stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_handled,
  output logic [1:0]         out_mouse_event,
  output logic signed [15:0] out_mouse_x,
  output logic signed [15:0] out_mouse_y,
  output logic [31:0]        out_fire_time_ms,
  output logic               out_last
);

  logic [OP_IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]         let_r, ldt_r, lut_r;
  logic                valid_r;
  logic                handled_r, last_r;
  logic [1:0]          ev_r;
  logic signed [15:0]  x_r, y_r;
  logic [31:0]         time_r;

  logic        advance, go, none_c, last_c;
  op_t         op;
  logic [31:0] now_let, t_c;

  assign advance = !valid_r || !out_stall;
  assign go      = advance && !stat.empty;
  assign op      = head.ops[idx_r];
  assign none_c  = head.nops == '0;
  assign last_c  = none_c || ((OP_CNT_W'(idx_r) + 1'b1) == head.nops);
  assign pop     = go && last_c;
  assign idx_nxt = last_c ? '0 : idx_r + 1'b1;
  assign now_let = tmax(head.now, let_r);

  always_comb begin
    case (op.tk)
      TK_PREMOVE: t_c = tmax(tadd(head.now, cfg.start), tadd(let_r, cfg.start));
      TK_DOWN:    t_c = tmax(tmax(tadd(head.now, cfg.down), tadd(let_r, cfg.down)),
                             tadd(lut_r, cfg.down));
      TK_UP:      t_c = tmax(now_let, tadd(ldt_r, cfg.up));
      TK_DTDOWN:  t_c = tmax(now_let, tadd(lut_r, cfg.down));
      TK_MOVE:    t_c = tmax(now_let, ldt_r);
      default:    t_c = now_let;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      let_r   <= '0;
      ldt_r   <= '0;
      lut_r   <= '0;
      valid_r <= 1'b0;
    end else if (go) begin
      idx_r   <= idx_nxt;
      valid_r <= 1'b1;
      if (!none_c) begin
        let_r <= t_c;
        if (op.tk inside {TK_DOWN, TK_DTDOWN}) begin
          ldt_r <= t_c;
        end
        if (op.tk == TK_UP) begin
          lut_r <= t_c;
        end
      end
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      handled_r <= head.handled;
      last_r    <= last_c;
      ev_r      <= none_c ? EV_NONE : op.ev;
      x_r       <= none_c ? 16'sd0 : op.x;
      y_r       <= none_c ? 16'sd0 : op.y;
      time_r    <= none_c ? 32'd0 : t_c;
    end
  end

  assign out_valid        = valid_r;
  assign out_handled      = handled_r;
  assign out_mouse_event  = ev_r;
  assign out_mouse_x      = x_r;
  assign out_mouse_y      = y_r;
  assign out_fire_time_ms = time_r;
  assign out_last         = last_r;

endmodule

// ===== rtl/core/touch_to_mouse_event_converter_top.sv =====
// Top level of the touch to mouse event converter: config registers, front end,
// command queue and back end. Uses ttm_pkg and the assertion macro header.
//
// Usage:
//   Input channel (in_*): one touch request per accepted valid/!stall edge.
//   Output channel (out_*): one mouse event per accepted edge; an input gives
//   one to five results, the final one flagged by out_last. An input that makes
//   no mouse event gives a single result with mouse_event none.
//   Config channel (cfg_*): cfg_ready is always high; write only while idle.
// Timing:
//   The front end takes one request per cycle while the two-entry command
//   queue has room. The back end issues one result per cycle while out_stall
//   is low and keeps a request until all of its results (1 to 5) are issued.
//   The first result is registered after the request is written to the queue.
// Reset: clears pointer state, event time history and the queue; config
//   registers return to their defaults (jitter 1, move trigger 5).
// Stall: the result register holds while out_stall is high; the queue fills
//   and then in_stall rises.
`include "touch_to_mouse_event_converter_top_macros.svh"

module touch_to_mouse_event_converter_top
  import ttm_pkg::*;
#(
  parameter int QUEUE_DEPTH = TTM_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_kind,
  input  logic [31:0]           in_pointer_tag,
  input  logic                  in_is_mouse,
  input  logic signed [15:0]    in_touch_x,
  input  logic signed [15:0]    in_touch_y,
  input  logic signed [15:0]    in_cursor_x,
  input  logic signed [15:0]    in_cursor_y,
  input  logic [31:0]           in_now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_handled,
  output logic [1:0]            out_mouse_event,
  output logic signed [15:0]    out_mouse_x,
  output logic signed [15:0]    out_mouse_y,
  output logic [31:0]           out_fire_time_ms,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  cmd_t    front_cmd, q_head;
  logic    push, pop;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{delay_en: 1'b0, start: 16'd0, down: 16'd0, up: 16'd0, dtap: 1'b0,
                 dead: 12'd0, jit: 12'd1, trig: 12'd5};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DELAY_EN:   cfg_r.delay_en <= cfg_data[0];
        CFG_START:      cfg_r.start    <= cfg_data;
        CFG_DOWN_DELAY: cfg_r.down     <= cfg_data;
        CFG_UP_DELAY:   cfg_r.up       <= cfg_data;
        CFG_DTAP:       cfg_r.dtap     <= cfg_data[0];
        CFG_DEAD_ZONE:  cfg_r.dead     <= cfg_data[11:0];
        CFG_JITTER:     cfg_r.jit      <= cfg_data[11:0];
        CFG_TRIGGER:    cfg_r.trig     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ttm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pointer_tag (in_pointer_tag),
    .in_is_mouse    (in_is_mouse),
    .in_touch_x     (in_touch_x),
    .in_touch_y     (in_touch_y),
    .in_cursor_x    (in_cursor_x),
    .in_cursor_y    (in_cursor_y),
    .in_now_ms      (in_now_ms),
    .push           (push),
    .cmd            (front_cmd)
  );

  ttm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .head   (q_head),
    .stat   (q_stat)
  );

  ttm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (q_head),
    .stat             (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_handled      (out_handled),
    .out_mouse_event  (out_mouse_event),
    .out_mouse_x      (out_mouse_x),
    .out_mouse_y      (out_mouse_y),
    .out_fire_time_ms (out_fire_time_ms),
    .out_last         (out_last)
  );

  `TTM_ASSERT_SAME(a_none_is_last, out_valid && out_mouse_event == EV_NONE, out_last)
  `TTM_ASSERT_SAME(a_unhandled_none, out_valid && !out_handled, out_mouse_event == EV_NONE)
  `TTM_ASSERT_SAME(a_queue_flags, 1'b1, !(q_stat.full && q_stat.empty))
  `TTM_ASSERT_NEXT(a_push_fills, in_valid && !in_stall, !q_stat.empty)

endmodule

// ===== dv/tb_touch_to_mouse_event_converter_top.sv =====
// Testbench for touch_to_mouse_event_converter_top: directed touch requests, then random gestures
// and noise under several register settings, checked against a behavioral predictor.
// Depends on ttm_pkg and the DUT only.
module tb_touch_to_mouse_event_converter_top;
  import ttm_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DIRECTED_ROWS = 25;
  localparam int HELD_ROW = 22;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 40;
  localparam int IDLE_PERCENT = 31;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        tag;
    logic               is_mouse;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [31:0]        now;
  } touch_req_t;

  typedef struct packed {
    logic               handled;
    logic [1:0]         ev;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        fire;
    logic               last;
  } mouse_result_t;

  typedef struct packed {
    touch_req_t    req;
    logic          golden;
    mouse_result_t want;
  } touch_row_t;

  typedef logic [CFG_DATA_W-1:0] reg_file_t [8];

  localparam mouse_result_t NOT_HANDLED = '{1'b0, EV_NONE, 16'sd0, 16'sd0, 32'd0, 1'b1};
  localparam mouse_result_t NO_EVENT = '{1'b1, EV_NONE, 16'sd0, 16'sd0, 32'd0, 1'b1};

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [31:0] in_pointer_tag = '0;
  logic in_is_mouse = 1'b0;
  logic signed [15:0] in_touch_x = '0;
  logic signed [15:0] in_touch_y = '0;
  logic signed [15:0] in_cursor_x = '0;
  logic signed [15:0] in_cursor_y = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_handled;
  logic [1:0] out_mouse_event;
  logic signed [15:0] out_mouse_x;
  logic signed [15:0] out_mouse_y;
  logic [31:0] out_fire_time_ms;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touch_to_mouse_event_converter_top dut (.*);

  // predictor state and register copies
  logic [31:0] tracked_tag = '0;
  logic touching = 1'b0;
  logic dragging = 1'b0;
  logic press_held = 1'b0;
  logic jitter_up = 1'b1;
  int raw_x = 0;
  int raw_y = 0;
  int press_x = 0;
  int press_y = 0;
  logic [31:0] last_fire = '0;
  logic [31:0] last_press_fire = '0;
  logic [31:0] last_release_fire = '0;
  logic delay_on = 1'b0;
  logic double_tap = 1'b0;
  logic [31:0] start_gap = '0;
  logic [31:0] press_gap = '0;
  logic [31:0] release_gap = '0;
  int dead_zone = 0;
  int jitter_step = 1;
  int trigger_dist = 5;

  mouse_result_t pending_events[$];
  mouse_result_t step_events[$];
  touch_row_t directed_rows [DIRECTED_ROWS];
  reg_file_t setting;
  logic [31:0] clock_ms = '0;
  logic idling = 1'b1;
  int failures = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= idling && ($urandom_range(99) < IDLE_PERCENT);
  end

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] later(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void post_event(logic [1:0] ev, int x, int y, logic [31:0] t);
    mouse_result_t r;
    if (step_events.size() >= MAX_OPS) return;
    r = '{1'b1, ev, 16'(x), 16'(y), t, 1'b0};
    step_events.push_back(r);
  endfunction

  function automatic void press_button(int x, int y, int cx, int cy, logic [31:0] now);
    if (cx - x < -trigger_dist || cx - x > trigger_dist ||
        cy - y < -trigger_dist || cy - y > trigger_dist) begin
      last_fire = later(sat_add(now, start_gap), sat_add(last_fire, start_gap));
      post_event(EV_MOVE, x, y, last_fire);
    end
    last_fire = later(sat_add(now, press_gap),
                      later(sat_add(last_fire, press_gap), sat_add(last_release_fire, press_gap)));
    last_press_fire = last_fire;
    post_event(EV_DOWN, x, y, last_fire);
    press_held = 1'b0;
  endfunction

  function automatic void convert_touch(touch_req_t req);
    int px;
    int py;
    int cx;
    int cy;
    logic handled;
    logic quiet;
    mouse_result_t r;
    px = req.tx;
    py = req.ty;
    cx = req.cx;
    cy = req.cy;
    handled = 1'b0;
    quiet = 1'b0;
    step_events.delete();
    if (req.is_mouse || (req.kind != KIND_DOWN && tracked_tag != req.tag)) begin
      handled = 1'b0;
    end else if (req.kind == KIND_DOWN && !touching) begin
      raw_x = px;
      raw_y = py;
      if (gap(px, press_x) <= jitter_step && gap(py, press_y) <= jitter_step) begin
        if (jitter_up) begin
          px = clip16(px + jitter_step);
          py = clip16(py + jitter_step);
        end else begin
          px = clip16(px - jitter_step);
          py = clip16(py - jitter_step);
        end
        jitter_up = !jitter_up;
      end
      press_x = px;
      press_y = py;
      if (delay_on) press_held = 1'b1;
      else press_button(px, py, cx, cy, req.now);
      tracked_tag = req.tag;
      touching = 1'b1;
      handled = 1'b1;
    end else if (req.kind == KIND_UP && touching) begin
      if (press_held) press_button(press_x, press_y, cx, cy, req.now);
      tracked_tag = '0;
      touching = 1'b0;
      dragging = 1'b0;
      last_fire = later(req.now, later(last_fire, sat_add(last_press_fire, release_gap)));
      last_release_fire = last_fire;
      if (gap(raw_x, px) <= dead_zone && gap(raw_y, py) <= dead_zone) begin
        px = raw_x;
        py = raw_y;
      end
      post_event(EV_UP, px, py, last_fire);
      handled = 1'b1;
    end else if (req.kind == KIND_UPDATE && touching) begin
      handled = 1'b1;
      if (!dragging) begin
        if (gap(raw_x, px) <= dead_zone && gap(raw_y, py) <= dead_zone) begin
          quiet = 1'b1;
        end else begin
          if (press_held) press_button(press_x, press_y, cx, cy, req.now);
          dragging = 1'b1;
          if (double_tap) begin
            last_fire = later(req.now, later(last_fire, sat_add(last_press_fire, release_gap)));
            last_release_fire = last_fire;
            post_event(EV_UP, press_x, press_y, last_fire);
            last_fire = later(req.now, later(last_fire, sat_add(last_release_fire, press_gap)));
            last_press_fire = last_fire;
            post_event(EV_DOWN, press_x, press_y, last_fire);
          end
        end
      end
      if (!quiet) begin
        last_fire = later(req.now, later(last_fire, last_press_fire));
        post_event(EV_MOVE, px, py, last_fire);
      end
    end
    if (step_events.size() == 0) begin
      r = '{handled, EV_NONE, 16'sd0, 16'sd0, 32'd0, 1'b1};
      step_events.push_back(r);
    end else begin
      step_events[step_events.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void compare_field(string name, logic signed [32:0] want,
                                        logic signed [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(negedge clk) begin : check_events
    mouse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("mouse event with no request outstanding");
        failures++;
      end else begin
        want = pending_events.pop_front();
        compare_field("handled", want.handled, out_handled);
        compare_field("mouse_event", want.ev, out_mouse_event);
        compare_field("mouse_x", want.x, out_mouse_x);
        compare_field("mouse_y", want.y, out_mouse_y);
        compare_field("fire_time_ms", want.fire, out_fire_time_ms);
        compare_field("last", want.last, out_last);
      end
    end
  end

  function automatic touch_req_t make_req(logic [1:0] kind, logic [31:0] tag, logic mouse,
                                          int tx, int ty, int cx, int cy, logic [31:0] now);
    touch_req_t r;
    r.kind = kind;
    r.tag = tag;
    r.is_mouse = mouse;
    r.tx = 16'(tx);
    r.ty = 16'(ty);
    r.cx = 16'(cx);
    r.cy = 16'(cy);
    r.now = now;
    return r;
  endfunction

  function automatic int rand_coord();
    logic signed [15:0] v;
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      default: begin
        v = 16'($urandom());
        return v;
      end
    endcase
  endfunction

  function automatic int rand_off(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int pick_cursor(int at);
    if ($urandom_range(1)) return clip16(at + rand_off(trigger_dist + 1));
    return rand_coord();
  endfunction

  function automatic logic [31:0] tick();
    case ($urandom_range(19))
      0: clock_ms = $urandom();
      1: clock_ms = 32'hFFFF_FFFF - $urandom_range(400);
      default: clock_ms = sat_add(clock_ms, $urandom_range(300));
    endcase
    return clock_ms;
  endfunction

  task automatic send_touch(input touch_req_t req, input logic golden, input mouse_result_t want);
    while (idling && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= req.kind;
    in_pointer_tag <= req.tag;
    in_is_mouse <= req.is_mouse;
    in_touch_x <= req.tx;
    in_touch_y <= req.ty;
    in_cursor_x <= req.cx;
    in_cursor_y <= req.cy;
    in_now_ms <= req.now;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    convert_touch(req);
    if (golden) pending_events.push_back(want);
    else foreach (step_events[k]) pending_events.push_back(step_events[k]);
  endtask

  task automatic send_random(input logic [1:0] kind, input logic [31:0] tag, input logic mouse,
                             input int x, input int y);
    send_touch(make_req(kind, tag, mouse, x, y, pick_cursor(x), pick_cursor(y), tick()),
               1'b0, NOT_HANDLED);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input reg_file_t vals);
    for (int i = 0; i <= CFG_TRIGGER; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      forever begin
        @(negedge clk);
        if (cfg_ready) break;
      end
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    delay_on = vals[CFG_DELAY_EN][0];
    start_gap = {16'd0, vals[CFG_START]};
    press_gap = {16'd0, vals[CFG_DOWN_DELAY]};
    release_gap = {16'd0, vals[CFG_UP_DELAY]};
    double_tap = vals[CFG_DTAP][0];
    dead_zone = int'(vals[CFG_DEAD_ZONE][11:0]);
    jitter_step = int'(vals[CFG_JITTER][11:0]);
    trigger_dist = int'(vals[CFG_TRIGGER][11:0]);
  endtask

  task automatic send_noise();
    logic [31:0] tag;
    tag = $urandom();
    case ($urandom_range(2))
      0: send_random(2'($urandom_range(3)), tag, 1'b1, rand_coord(), rand_coord());
      1: send_random(KIND_UNUSED, tracked_tag, 1'b0, rand_coord(), rand_coord());
      default: begin
        if (touching && $urandom_range(1)) begin
          send_random(KIND_DOWN, tag, 1'b0, rand_coord(), rand_coord());
        end else if (touching) begin
          send_random($urandom_range(1) ? KIND_UP : KIND_UPDATE, tracked_tag ^ (tag | 32'd1),
                      1'b0, rand_coord(), rand_coord());
        end else begin
          send_random($urandom_range(1) ? KIND_UP : KIND_UPDATE, tag, 1'b0,
                      rand_coord(), rand_coord());
        end
      end
    endcase
  endtask

  task automatic run_gestures(input int count);
    int sent;
    int bx;
    int by;
    int reach;
    logic [31:0] tag;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(7))
        0: tag = '0;
        1: tag = 32'hFFFF_FFFF;
        default: tag = $urandom();
      endcase
      if ($urandom_range(2) == 0) begin
        bx = clip16(press_x + rand_off(jitter_step + 1));
        by = clip16(press_y + rand_off(jitter_step + 1));
      end else begin
        bx = rand_coord();
        by = rand_coord();
      end
      send_random(KIND_DOWN, tag, 1'b0, bx, by);
      sent++;
      repeat ($urandom_range(4)) begin
        if ($urandom_range(4) == 0) send_noise();
        reach = $urandom_range(1) ? dead_zone : 2 * dead_zone + 16;
        send_random(KIND_UPDATE, tag, 1'b0, clip16(bx + rand_off(reach)),
                    clip16(by + rand_off(reach)));
        sent++;
      end
      if ($urandom_range(4) == 0) send_noise();
      reach = $urandom_range(1) ? dead_zone : 2 * dead_zone + 16;
      send_random(KIND_UP, tag, 1'b0, clip16(bx + rand_off(reach)), clip16(by + rand_off(reach)));
      sent++;
      if ($urandom_range(4) == 0) send_noise();
    end
  endtask

  initial begin
    directed_rows[0] = '{make_req(KIND_UP, 32'd0, 1'b0, 0, 0, 0, 0, 32'd0), 1'b1, NOT_HANDLED};
    directed_rows[1] = '{make_req(KIND_UPDATE, 32'd0, 1'b0, 0, 0, 0, 0, 32'd5), 1'b1,
                         NOT_HANDLED};
    directed_rows[2] = '{make_req(KIND_UNUSED, 32'd0, 1'b0, 7, 7, 7, 7, 32'd6), 1'b1,
                         NOT_HANDLED};
    directed_rows[3] = '{make_req(KIND_DOWN, 32'hFFFF_FFFF, 1'b1, 100, 100, 100, 100, 32'd900),
                         1'b1, NOT_HANDLED};
    directed_rows[4] = '{make_req(KIND_DOWN, 32'hFFFF_FFFF, 1'b0, 100, 100, 100, 100, 32'd1000),
                         1'b1, '{1'b1, EV_DOWN, 16'sd100, 16'sd100, 32'd1000, 1'b1}};
    directed_rows[5] = '{make_req(KIND_DOWN, 32'hFFFF_FFFF, 1'b0, 50, 50, 50, 50, 32'd1000),
                         1'b1, NOT_HANDLED};
    directed_rows[6] = '{make_req(KIND_UPDATE, 32'd0, 1'b0, 100, 100, 0, 0, 32'd1000), 1'b1,
                         NOT_HANDLED};
    directed_rows[7] = '{make_req(KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 100, 100, 0, 0, 32'd1001),
                         1'b1, NO_EVENT};
    directed_rows[8] = '{make_req(KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 32767, -32768, 0, 0, 32'd0),
                         1'b0, NOT_HANDLED};
    directed_rows[9] = '{make_req(KIND_UP, 32'hFFFF_FFFF, 1'b0, -32768, 32767, 0, 0,
                                  32'hFFFF_FFFF), 1'b0, NOT_HANDLED};
    directed_rows[10] = '{make_req(KIND_DOWN, 32'd1, 1'b0, 101, 101, -32768, 32767, 32'd2000),
                          1'b0, NOT_HANDLED};
    directed_rows[11] = '{make_req(KIND_UP, 32'd1, 1'b0, 101, 101, 0, 0, 32'd2001), 1'b0,
                          NOT_HANDLED};
    directed_rows[12] = '{make_req(KIND_DOWN, 32'd1, 1'b0, 102, 102, 102, 102, 32'd2002), 1'b0,
                          NOT_HANDLED};
    directed_rows[13] = '{make_req(KIND_UP, 32'd1, 1'b0, 102, 102, 0, 0, 32'd2003), 1'b0,
                          NOT_HANDLED};
    directed_rows[14] = '{make_req(KIND_DOWN, 32'd2, 1'b0, 32767, 32767, 32767, 32767, 32'd3000),
                          1'b0, NOT_HANDLED};
    directed_rows[15] = '{make_req(KIND_UP, 32'd2, 1'b0, 32767, 32767, 0, 0, 32'd3001), 1'b0,
                          NOT_HANDLED};
    directed_rows[16] = '{make_req(KIND_DOWN, 32'd2, 1'b0, 32767, 32767, 32767, 32767, 32'd3002),
                          1'b0, NOT_HANDLED};
    directed_rows[17] = '{make_req(KIND_UP, 32'd2, 1'b0, 32767, 32767, 0, 0, 32'd3003), 1'b0,
                          NOT_HANDLED};
    directed_rows[18] = '{make_req(KIND_DOWN, 32'd3, 1'b0, -32768, -32768, -32768, -32768,
                                   32'd3004), 1'b0, NOT_HANDLED};
    directed_rows[19] = '{make_req(KIND_UP, 32'd3, 1'b0, -32768, -32768, 0, 0, 32'd3005), 1'b0,
                          NOT_HANDLED};
    directed_rows[20] = '{make_req(KIND_DOWN, 32'd3, 1'b0, -32768, -32768, -32768, -32768,
                                   32'd3006), 1'b0, NOT_HANDLED};
    directed_rows[21] = '{make_req(KIND_UP, 32'd3, 1'b0, -32768, -32768, 0, 0, 32'd3007), 1'b0,
                          NOT_HANDLED};
    directed_rows[22] = '{make_req(KIND_DOWN, 32'hA5A5_5A5A, 1'b0, 0, 0, 0, 0, 32'hFFFF_0000),
                          1'b1, NO_EVENT};
    directed_rows[23] = '{make_req(KIND_UPDATE, 32'hA5A5_5A5A, 1'b0, 32767, 32767, -32768,
                                   -32768, 32'hFFFF_FFF0), 1'b0, NOT_HANDLED};
    directed_rows[24] = '{make_req(KIND_UP, 32'hA5A5_5A5A, 1'b0, 32767, 32767, 0, 0,
                                   32'hFFFF_FFF8), 1'b0, NOT_HANDLED};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == HELD_ROW) begin
        wait_quiet();
        setting = '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFF, 16'hFFF, 16'd0};
        apply_settings(setting);
      end
      send_touch(directed_rows[i].req, directed_rows[i].golden, directed_rows[i].want);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0: setting = '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFF, 16'hFFF, 16'hFFF};
        1: setting = '{default: 16'd0};
        default: begin
          setting[CFG_DELAY_EN] = 16'($urandom_range(1));
          setting[CFG_START] = 16'($urandom_range(500));
          setting[CFG_DOWN_DELAY] = 16'($urandom_range(500));
          setting[CFG_UP_DELAY] = 16'($urandom_range(500));
          setting[CFG_DTAP] = 16'($urandom_range(1));
          setting[CFG_DEAD_ZONE] = 16'($urandom_range(40));
          setting[CFG_JITTER] = 16'($urandom_range(8));
          setting[CFG_TRIGGER] = 16'($urandom_range(30));
        end
      endcase
      apply_settings(setting);
      idling <= (phase != 2);
      run_gestures(PHASE_ITEMS);
    end

    wait_quiet();
    if (failures == 0 && pending_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
